### hdl/g3ca_pkg.sv
package g3ca_pkg;

    localparam int GRID_X     = 16;
    localparam int GRID_Y     = 16;
    localparam int GRID_Z     = 16;
    localparam int STATE_BITS = 4;

    localparam int NCELLS   = GRID_X * GRID_Y * GRID_Z;
    localparam int ADDR_W   = $clog2(NCELLS);
    localparam int XW       = $clog2(GRID_X);
    localparam int YW       = $clog2(GRID_Y);
    localparam int ZW       = $clog2(GRID_Z);
    localparam int CELL_MAX = (1 << STATE_BITS) - 1;

    localparam int OP_W    = 2;
    localparam int IDX_W   = 12;
    localparam int VAL_W   = 4;
    localparam int CFG_IW  = 2;
    localparam int CFG_DW  = 27;
    localparam int MASK_W  = 27;
    localparam int CNT_W   = 5;

    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_GEN  = 2'd1;

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_GEN  = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    localparam logic [CFG_IW-1:0] REG_MAX_STATE = 2'd0;
    localparam logic [CFG_IW-1:0] REG_SURVIVE   = 2'd1;
    localparam logic [CFG_IW-1:0] REG_BIRTH     = 2'd2;
    localparam logic [CFG_IW-1:0] REG_MODE      = 2'd3;

    typedef logic [STATE_BITS-1:0] t_cell;
    typedef logic [ADDR_W-1:0]     t_addr;

    typedef struct packed {
        logic clr;
        logic accept;
        logic gen_start;
        logic issue;
        logic wr;
        logic swap;
        logic rd_cap;
        logic res_set;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic k_last;
        logic cell_last;
    } t_status;

    function automatic t_cell eff_max(input logic [VAL_W-1:0] ms);
        int m;
        m = int'(ms);
        if (m == 0) m = 1;
        if (m > CELL_MAX) m = CELL_MAX;
        return t_cell'(m);
    endfunction

endpackage

### hdl/g3ca_ram.sv
module g3ca_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### hdl/g3ca_ctrl.sv
module g3ca_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [g3ca_pkg::OP_W-1:0] i_opcode,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    input  g3ca_pkg::t_status        i_status,
    output g3ca_pkg::t_cmd           o_cmd
);
    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_RDWAIT = 3'd2;
    localparam logic [2:0] ST_ISSUE  = 3'd3;
    localparam logic [2:0] ST_WAIT   = 3'd4;
    localparam logic [2:0] ST_WRITE  = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       accept;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_status.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.accept = 1'b1;
                    if (i_opcode == g3ca_pkg::OP_GEN) begin
                        o_cmd.gen_start = 1'b1;
                        n_state = ST_ISSUE;
                    end else if (i_opcode == g3ca_pkg::OP_LOAD) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_RDWAIT;
                    end
                end
            end
            ST_RDWAIT: begin
                o_cmd.rd_cap = 1'b1;
                n_state = ST_DONE;
            end
            ST_ISSUE: begin
                o_cmd.issue = 1'b1;
                if (i_status.k_last) n_state = ST_WAIT;
            end
            ST_WAIT: begin
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                o_cmd.wr = 1'b1;
                if (i_status.cell_last) begin
                    o_cmd.swap = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_ISSUE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.res_set = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) n_out_valid = 1'b0;
        if (o_cmd.res_set) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

### hdl/g3ca_dp.sv
module g3ca_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  g3ca_pkg::t_cmd              i_cmd,
    output g3ca_pkg::t_status           o_status,
    input  logic [g3ca_pkg::OP_W-1:0]   i_opcode,
    input  logic [g3ca_pkg::IDX_W-1:0]  i_cell_index,
    input  logic [g3ca_pkg::VAL_W-1:0]  i_cell_value,
    input  logic                        i_cfg_we,
    input  logic [g3ca_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [g3ca_pkg::CFG_DW-1:0] i_cfg_data,
    output logic [g3ca_pkg::VAL_W-1:0]  o_read_value,
    output logic [1:0]                  o_ack_kind
);
    localparam int XW = g3ca_pkg::XW;
    localparam int YW = g3ca_pkg::YW;
    localparam int ZW = g3ca_pkg::ZW;

    logic [g3ca_pkg::VAL_W-1:0]  r_max_state;
    logic [g3ca_pkg::MASK_W-1:0] r_survive, r_birth;
    logic                        r_mode;
    logic                        r_bank;

    logic [XW-1:0] r_x;
    logic [YW-1:0] r_y;
    logic [ZW-1:0] r_z;
    logic [1:0]    r_kx, r_ky, r_kz;
    g3ca_pkg::t_addr r_clr;

    logic                        r_tg_valid, r_tg_center, r_tg_count;
    logic [g3ca_pkg::CNT_W-1:0]  r_cnt;
    g3ca_pkg::t_cell             r_self;
    g3ca_pkg::t_cell             r_rd;
    logic [1:0]                  r_kind;
    logic                        r_inrange;
    logic [g3ca_pkg::VAL_W-1:0]  r_out_rd;
    logic [1:0]                  r_out_kind;

    g3ca_pkg::t_cell m, ld_val, rdata, rdata0, rdata1, new_val;
    g3ca_pkg::t_addr in_addr, nb_addr, self_addr, raddr, waddr;
    g3ca_pkg::t_cell wdata;
    logic            in_range, do_load, we0, we1;
    logic [XW-1:0]   nx;
    logic [YW-1:0]   ny;
    logic [ZW-1:0]   nz;
    logic [1:0]      nb_span;
    logic            x_last, y_last, z_last;

    assign m        = g3ca_pkg::eff_max(r_max_state);
    assign in_range = int'(i_cell_index) < g3ca_pkg::NCELLS;
    assign in_addr  = g3ca_pkg::ADDR_W'(i_cell_index);
    assign ld_val   = (int'(i_cell_value) > int'(m)) ? m
                                                     : g3ca_pkg::t_cell'(i_cell_value);
    assign do_load  = i_cmd.accept && (i_opcode == g3ca_pkg::OP_LOAD) && in_range;

    // wrapped neighbour coordinates
    always_comb begin
        case (r_kx)
            2'd0:    nx = (r_x == '0) ? XW'(g3ca_pkg::GRID_X - 1) : r_x - XW'(1);
            2'd2:    nx = (r_x == XW'(g3ca_pkg::GRID_X - 1)) ? '0 : r_x + XW'(1);
            default: nx = r_x;
        endcase
        case (r_ky)
            2'd0:    ny = (r_y == '0) ? YW'(g3ca_pkg::GRID_Y - 1) : r_y - YW'(1);
            2'd2:    ny = (r_y == YW'(g3ca_pkg::GRID_Y - 1)) ? '0 : r_y + YW'(1);
            default: ny = r_y;
        endcase
        case (r_kz)
            2'd0:    nz = (r_z == '0) ? ZW'(g3ca_pkg::GRID_Z - 1) : r_z - ZW'(1);
            2'd2:    nz = (r_z == ZW'(g3ca_pkg::GRID_Z - 1)) ? '0 : r_z + ZW'(1);
            default: nz = r_z;
        endcase
    end

    assign nb_addr = g3ca_pkg::ADDR_W'((int'(ny) * g3ca_pkg::GRID_Z + int'(nz))
                                       * g3ca_pkg::GRID_X + int'(nx));
    assign self_addr = g3ca_pkg::ADDR_W'((int'(r_y) * g3ca_pkg::GRID_Z + int'(r_z))
                                         * g3ca_pkg::GRID_X + int'(r_x));
    assign nb_span = 2'(r_kx != 2'd1) + 2'(r_ky != 2'd1) + 2'(r_kz != 2'd1);

    assign x_last = (r_x == XW'(g3ca_pkg::GRID_X - 1));
    assign y_last = (r_y == YW'(g3ca_pkg::GRID_Y - 1));
    assign z_last = (r_z == ZW'(g3ca_pkg::GRID_Z - 1));

    assign o_status.clr_last  = (r_clr == g3ca_pkg::ADDR_W'(g3ca_pkg::NCELLS - 1));
    assign o_status.k_last    = (r_kx == 2'd2) && (r_ky == 2'd2) && (r_kz == 2'd2);
    assign o_status.cell_last = x_last && y_last && z_last;

    // generations rule
    always_comb begin
        if (r_self == m) begin
            new_val = r_survive[r_cnt] ? m : m - g3ca_pkg::t_cell'(1);
        end else if (r_self != '0) begin
            new_val = r_self - g3ca_pkg::t_cell'(1);
        end else begin
            new_val = r_birth[r_cnt] ? m : '0;
        end
    end

    assign raddr = i_cmd.issue ? nb_addr : in_addr;
    always_comb begin
        if (i_cmd.clr) begin
            waddr = r_clr;
            wdata = '0;
        end else if (i_cmd.wr) begin
            waddr = self_addr;
            wdata = new_val;
        end else begin
            waddr = in_addr;
            wdata = ld_val;
        end
    end
    assign we0 = i_cmd.clr || (do_load && !r_bank) || (i_cmd.wr && r_bank);
    assign we1 = (do_load && r_bank) || (i_cmd.wr && !r_bank);
    assign rdata = r_bank ? rdata1 : rdata0;

    g3ca_ram #(.WIDTH(g3ca_pkg::STATE_BITS), .DEPTH(g3ca_pkg::NCELLS)) u_ram0 (
        .i_clk   (i_clk),
        .i_we    (we0),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata0)
    );

    g3ca_ram #(.WIDTH(g3ca_pkg::STATE_BITS), .DEPTH(g3ca_pkg::NCELLS)) u_ram1 (
        .i_clk   (i_clk),
        .i_we    (we1),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_state <= g3ca_pkg::VAL_W'(1);
            r_survive   <= '0;
            r_birth     <= '0;
            r_mode      <= 1'b0;
            r_bank      <= 1'b0;
            r_clr       <= '0;
            r_tg_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    g3ca_pkg::REG_MAX_STATE: r_max_state <= i_cfg_data[g3ca_pkg::VAL_W-1:0];
                    g3ca_pkg::REG_SURVIVE:   r_survive   <= i_cfg_data[g3ca_pkg::MASK_W-1:0];
                    g3ca_pkg::REG_BIRTH:     r_birth     <= i_cfg_data[g3ca_pkg::MASK_W-1:0];
                    g3ca_pkg::REG_MODE:      r_mode      <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.clr) r_clr <= r_clr + g3ca_pkg::ADDR_W'(1);
            if (i_cmd.swap) r_bank <= ~r_bank;
            r_tg_valid <= i_cmd.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tg_center <= (nb_span == 2'd0);
        r_tg_count  <= (nb_span != 2'd0) && (!r_mode || nb_span == 2'd1);

        if (i_cmd.gen_start) begin
            r_x  <= '0;
            r_y  <= '0;
            r_z  <= '0;
            r_kx <= '0;
            r_ky <= '0;
            r_kz <= '0;
        end else if (i_cmd.issue) begin
            // walk the 27 offsets, z fastest
            if (r_kz == 2'd2) begin
                r_kz <= '0;
                if (r_ky == 2'd2) begin
                    r_ky <= '0;
                    r_kx <= (r_kx == 2'd2) ? 2'd0 : r_kx + 2'd1;
                end else begin
                    r_ky <= r_ky + 2'd1;
                end
            end else begin
                r_kz <= r_kz + 2'd1;
            end
        end else if (i_cmd.wr) begin
            if (x_last) begin
                r_x <= '0;
                if (z_last) begin
                    r_z <= '0;
                    r_y <= y_last ? '0 : r_y + YW'(1);
                end else begin
                    r_z <= r_z + ZW'(1);
                end
            end else begin
                r_x <= r_x + XW'(1);
            end
        end

        if (i_cmd.gen_start || i_cmd.wr) begin
            r_cnt <= '0;
        end else if (r_tg_valid) begin
            if (r_tg_count && rdata == m) r_cnt <= r_cnt + g3ca_pkg::CNT_W'(1);
            if (r_tg_center) r_self <= rdata;
        end

        if (i_cmd.accept) begin
            r_inrange <= in_range;
            case (i_opcode)
                g3ca_pkg::OP_LOAD: r_kind <= g3ca_pkg::KIND_LOAD;
                g3ca_pkg::OP_GEN:  r_kind <= g3ca_pkg::KIND_GEN;
                default:           r_kind <= g3ca_pkg::KIND_READ;
            endcase
        end
        if (i_cmd.rd_cap) r_rd <= rdata;
        if (i_cmd.res_set) begin
            r_out_kind <= r_kind;
            r_out_rd   <= (r_kind == g3ca_pkg::KIND_READ && r_inrange)
                          ? g3ca_pkg::VAL_W'(r_rd) : '0;
        end
    end

    assign o_read_value = r_out_rd;
    assign o_ack_kind   = r_out_kind;
endmodule

### hdl/generations_3d_cellular_automaton_core.sv
// 3D toroidal generations cellular automaton with a double-buffered grid.
// Input channel (i_in_valid / o_in_stall) carries one operation per
// transaction: load a cell (value saturated to max_state), read a cell, or
// run one generation over the whole grid. Output channel (o_out_valid /
// i_out_stall) returns exactly one result per operation, in order.
// Each generation makes 27 neighbourhood reads per cell through the single
// read port of the grid memory, then one drain and one write per cell.
// Throughput: one operation at a time; a new one is taken when the previous
// result has moved into the output register, even while that result waits.
// Configuration is a plain write port (index 0 max_state, 1 survive_mask,
// 2 birth_mask, 3 neighbourhood_mode); the user must write it only while idle,
// which the block does not enforce. Reset: synchronous active low; afterwards
// the grid is zeroed by a clearing pass during which input is stalled.
// When the receiver stalls, the result holds and the next result waits.
module generations_3d_cellular_automaton_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [g3ca_pkg::OP_W-1:0]   i_opcode,
    input  logic [g3ca_pkg::IDX_W-1:0]  i_cell_index,
    input  logic [g3ca_pkg::VAL_W-1:0]  i_cell_value,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [g3ca_pkg::VAL_W-1:0]  o_read_value,
    output logic [1:0]                  o_ack_kind,
    input  logic                        i_cfg_we,
    input  logic [g3ca_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [g3ca_pkg::CFG_DW-1:0] i_cfg_data
);
    g3ca_pkg::t_cmd    cmd;
    g3ca_pkg::t_status status;

    g3ca_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    g3ca_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_opcode     (i_opcode),
        .i_cell_index (i_cell_index),
        .i_cell_value (i_cell_value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_read_value (o_read_value),
        .o_ack_kind   (o_ack_kind)
    );
endmodule

### hdl/g3ca_chk.sv
module g3ca_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic [g3ca_pkg::VAL_W-1:0] o_read_value,
    input logic [1:0]                 o_ack_kind
);
    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_reset_clear: assert property (@(posedge i_clk) !i_rst_n |=> o_in_stall)
        else $error("input taken during grid clear");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_read_value)
                                       && $stable(o_ack_kind))
        else $error("stalled result changed");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_ack_kind == g3ca_pkg::KIND_LOAD
                     || o_ack_kind == g3ca_pkg::KIND_GEN
                     || o_ack_kind == g3ca_pkg::KIND_READ)
        else $error("bad ack kind");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_ack_kind != g3ca_pkg::KIND_READ |-> o_read_value == '0)
        else $error("nonzero value on non-read result");
endmodule

bind generations_3d_cellular_automaton_core g3ca_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_read_value (o_read_value),
    .o_ack_kind   (o_ack_kind)
);
